FILE: hw/rtl/hbd_pkg.sv
`timescale 1ns / 1ps
package hbd_pkg;

    localparam int MAX_CODE_LEN  = 32;
    localparam int ALPHABET_SIZE = 256;
    localparam int BYTE_BITS     = 8;
    localparam int SYM_W         = 8;
    localparam int LEN_W         = 6;
    localparam int CODE_W        = 32;
    localparam int CNT_W         = 4;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SYM_W-1:0]  entry_symbol;
        logic [LEN_W-1:0]  entry_length;
        logic [CODE_W-1:0] entry_code;
        logic [7:0]        data_byte;
        logic [CNT_W-1:0]  valid_bits;
    } in_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             has_symbol;
        logic             overflow_error;
        logic             last;
    } out_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] pos;
    } match_t;

endpackage

FILE: hw/rtl/hbd_match.sv
`timescale 1ns / 1ps
module hbd_match
    import hbd_pkg::*;
(
    input  logic [CODE_W-1:0] acc,
    input  logic [LEN_W-1:0]  acc_len,
    input  logic [7:0]        bits,
    input  logic [CNT_W-1:0]  rem,
    input  logic              ent_valid,
    input  logic [LEN_W-1:0]  ent_len,
    input  logic [CODE_W-1:0] ent_code,
    output match_t            result
);

    logic [LEN_W-1:0]  diff;
    logic [CNT_W-1:0]  pos;
    logic              in_reach;
    logic [CODE_W-1:0] expect_code;

    // Entry matches once acc_len + pos bits are gathered, pos within the remaining bits.
    always_comb
    begin
        diff        = ent_len - acc_len;
        in_reach    = ent_valid && (ent_len > acc_len) && (diff <= {2'b00, rem});
        pos         = diff[CNT_W-1:0];
        expect_code = (acc << pos) | ({24'd0, bits} >> (4'd8 - pos));
        result.hit  = in_reach && (expect_code == ent_code);
        result.pos  = pos;
    end

endmodule

FILE: hw/rtl/huffman_bit_decoder_core.sv
`timescale 1ns / 1ps
// Huffman bit decoder core.
// Input channel (in_valid/in_ready/in_data) takes clear, load and decode items;
// output channel (out_valid/out_ready/out_data) returns one result per decoded
// symbol or overflow, with last set on the final result of a decode item.
// Clear and load items act when accepted and give no result.
// A decode item runs one or more scans of the code memory: each scan reads all
// 256 entries through the single read port and a resolve step follows; it finds
// the earliest bit position at which any entry matches. One scan runs per
// emitted result, plus one more when bits remain after the last result, and
// the byte holds the input until all of its scans are done.
// The code memory holds length and code per symbol; entry valid bits sit in
// flops, so a clear item empties the table without a clearing pass.
// Reset empties the table and the bit accumulator, no clearing pass.
// A result is held back in a pending register so its last flag is known; when the receiver
// stalls the output register holds and the scan waits in its resolve step.
module huffman_bit_decoder_core
    import hbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [LEN_W+CODE_W-1:0] mem [ALPHABET_SIZE];
    logic [LEN_W+CODE_W-1:0] rdata_reg;
    logic [ALPHABET_SIZE-1:0] valid_reg, valid_next;

    logic [1:0]        state_reg, state_next;
    logic [8:0]        addr_reg, addr_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [7:0]        cmp_addr_reg;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0]  acc_len_reg, acc_len_next;
    logic [7:0]        bits_reg, bits_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  best_pos_reg, best_pos_next;
    logic [SYM_W-1:0]  best_sym_reg, best_sym_next;
    logic              pend_vld_reg, pend_vld_next;
    out_t              pend_reg, pend_next;
    logic              out_vld_reg, out_vld_next;
    out_t              out_reg, out_next;

    logic              accept, out_free, push;
    logic              mem_we;
    logic [CODE_W-1:0] load_code;
    logic [CNT_W-1:0]  nbits, use_pos;
    logic              ovf, newres;
    match_t            m;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_vld_reg || out_ready;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign mem_we    = accept && (in_data.mode == MODE_LOAD)
                       && (in_data.entry_length != '0)
                       && (int'(in_data.entry_length) <= MAX_CODE_LEN);
    assign load_code = in_data.entry_code
                       & CODE_W'((33'd1 << in_data.entry_length) - 33'd1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[in_data.entry_symbol] <= {in_data.entry_length, load_code};
        if (state_reg == ST_SCAN && !addr_reg[8])
            rdata_reg <= mem[addr_reg[7:0]];
    end

    hbd_match u_match (
        .acc       (acc_reg),
        .acc_len   (acc_len_reg),
        .bits      (bits_reg),
        .rem       (rem_reg),
        .ent_valid (cmp_vld_reg && valid_reg[cmp_addr_reg]),
        .ent_len   (rdata_reg[LEN_W+CODE_W-1:CODE_W]),
        .ent_code  (rdata_reg[CODE_W-1:0]),
        .result    (m)
    );

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cmp_vld_next  = 1'b0;
        valid_next    = valid_reg;
        acc_next      = acc_reg;
        acc_len_next  = acc_len_reg;
        bits_next     = bits_reg;
        rem_next      = rem_reg;
        best_pos_next = best_pos_reg;
        best_sym_next = best_sym_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_next      = out_reg;
        push          = 1'b0;
        nbits         = (in_data.valid_bits > 4'd8) ? 4'd8 : in_data.valid_bits;
        ovf           = (6'(acc_len_reg) + 6'(rem_reg)) >= LEN_W'(MAX_CODE_LEN);
        newres        = (best_pos_reg != '0) || ovf;
        use_pos       = (best_pos_reg != '0) ? best_pos_reg
                        : CNT_W'(LEN_W'(MAX_CODE_LEN) - acc_len_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.mode)
                        MODE_CLEAR:
                        begin
                            valid_next   = '0;
                            acc_next     = '0;
                            acc_len_next = '0;
                        end
                        MODE_LOAD:
                        begin
                            if (int'(in_data.entry_symbol) < ALPHABET_SIZE)
                                valid_next[in_data.entry_symbol] = mem_we;
                        end
                        MODE_DECODE:
                        begin
                            if (nbits != '0)
                            begin
                                bits_next     = in_data.data_byte;
                                rem_next      = nbits;
                                addr_next     = '0;
                                best_pos_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!addr_reg[8])
                    addr_next = addr_reg + 9'd1;
                cmp_vld_next = !addr_reg[8];
                // keep the earliest position; ties go to the lower symbol
                if (m.hit && (best_pos_reg == '0 || m.pos < best_pos_reg))
                begin
                    best_pos_next = m.pos;
                    best_sym_next = cmp_addr_reg;
                end
                if (cmp_vld_reg && cmp_addr_reg == 8'(ALPHABET_SIZE - 1))
                    state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (!(newres && pend_vld_reg && !out_free))
                begin
                    if (newres)
                    begin
                        bits_next    = bits_reg << use_pos;
                        rem_next     = rem_reg - use_pos;
                        acc_next     = '0;
                        acc_len_next = '0;
                        if (pend_vld_reg)
                        begin
                            push         = 1'b1;
                            out_vld_next = 1'b1;
                            out_next     = pend_reg;
                        end
                        pend_vld_next            = 1'b1;
                        pend_next.symbol         = (best_pos_reg != '0) ? best_sym_reg : '0;
                        pend_next.has_symbol     = (best_pos_reg != '0);
                        pend_next.overflow_error = (best_pos_reg == '0);
                        pend_next.last           = 1'b0;
                    end
                    else
                    begin
                        acc_next     = (acc_reg << rem_reg)
                                       | ({24'd0, bits_reg} >> (4'd8 - rem_reg));
                        acc_len_next = acc_len_reg + 6'(rem_reg);
                        rem_next     = '0;
                    end
                    addr_next     = '0;
                    best_pos_next = '0;
                    if (newres && rem_reg != use_pos)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!pend_vld_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    push          = 1'b1;
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            acc_reg      <= '0;
            acc_len_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            addr_reg     <= '0;
            rem_reg      <= '0;
            best_pos_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            acc_reg      <= acc_next;
            acc_len_reg  <= acc_len_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            addr_reg     <= addr_next;
            rem_reg      <= rem_next;
            best_pos_reg <= best_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= addr_reg[7:0];
        bits_reg     <= bits_next;
        best_sym_reg <= best_sym_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    a_scan_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> rem_reg != '0)
        else $error("scan without bits");

    a_acc_short: assert property (@(posedge clk) disable iff (!rst_n)
        int'(acc_len_reg) < MAX_CODE_LEN)
        else $error("accumulator too long");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_vld_reg |-> out_ready)
        else $error("output overwritten");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_vld_reg)
        else $error("result left pending");

endmodule

FILE: test/tb_huffman_bit_decoder_core.sv
`timescale 1ns / 1ps
module tb_huffman_bit_decoder_core;
    import hbd_pkg::*;

    localparam int IDLE_LIMIT = 30000;
    localparam int DRAIN_CYCLES = 2600;
    localparam int RANDOM_ITEMS = 156;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // predictor copy of the code table and accumulator
    bit              tbl_valid [ALPHABET_SIZE];
    int              tbl_len   [ALPHABET_SIZE];
    logic [31:0]     tbl_code  [ALPHABET_SIZE];
    logic [31:0]     acc_bits;
    int              acc_len;

    out_t            pending_results[$];
    stim_row_t       directed[$];
    int              fail_count;
    int              idle_cycles;
    int              symbols_seen;
    int              overflows_seen;
    int              burst_left;

    huffman_bit_decoder_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic in_t make_item(logic [1:0] mode, int sym, int len, logic [31:0] code,
                                      int dbyte, int nbits);
        in_t it;
        it.mode = mode;
        it.entry_symbol = sym[7:0];
        it.entry_length = len[5:0];
        it.entry_code = code;
        it.data_byte = dbyte[7:0];
        it.valid_bits = nbits[3:0];
        return it;
    endfunction

    task automatic add_row(in_t it, bit typed = 1'b0, out_t want = '0);
        stim_row_t r;
        r.item = it;
        r.typed = typed;
        r.want = want;
        directed = {directed, r};
    endtask

    task automatic clear_decoder();
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_len[i] = 0;
            tbl_code[i] = '0;
        end
        acc_bits = '0;
        acc_len = 0;
    endtask

    // Run one item through the predictor; returns the results it causes.
    task automatic decode_item(in_t it, output out_t res[$]);
        int nbits;
        int hit;
        logic [31:0] mask;
        out_t r;
        res = {};
        case (it.mode)
            MODE_CLEAR: clear_decoder();
            MODE_LOAD:
            begin
                if (it.entry_length == 0 || it.entry_length > MAX_CODE_LEN)
                begin
                    tbl_valid[it.entry_symbol] = 1'b0;
                    tbl_len[it.entry_symbol] = 0;
                    tbl_code[it.entry_symbol] = '0;
                end
                else
                begin
                    mask = (it.entry_length == 32) ? '1 : ((32'd1 << it.entry_length) - 1);
                    tbl_valid[it.entry_symbol] = 1'b1;
                    tbl_len[it.entry_symbol] = it.entry_length;
                    tbl_code[it.entry_symbol] = it.entry_code & mask;
                end
            end
            MODE_DECODE:
            begin
                nbits = (it.valid_bits > BYTE_BITS) ? BYTE_BITS : it.valid_bits;
                for (int b = 0; b < nbits; b++)
                begin
                    acc_bits = {acc_bits[30:0], it.data_byte[BYTE_BITS-1-b]};
                    acc_len++;
                    hit = -1;
                    for (int s = 0; s < ALPHABET_SIZE && hit < 0; s++)
                        if (tbl_valid[s] && tbl_len[s] == acc_len && tbl_code[s] == acc_bits)
                            hit = s;
                    r = '0;
                    if (hit >= 0)
                    begin
                        r.symbol = hit[7:0];
                        r.has_symbol = 1'b1;
                    end
                    else if (acc_len >= MAX_CODE_LEN)
                        r.overflow_error = 1'b1;
                    if (r.has_symbol || r.overflow_error)
                    begin
                        res = {res, r};
                        acc_bits = '0;
                        acc_len = 0;
                    end
                end
                if (res.size() > 0)
                    res[res.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Present one item; valid stays high into the next item unless a gap is drawn.
    task automatic send_item(stim_row_t row);
        out_t res[$];
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        in_data = row.item;
        do
            @(posedge clk);
        while (!in_ready);
        decode_item(row.item, res);
        if (row.typed)
        begin
            // a typed row without symbol or overflow expects no result at all
            if (row.want.has_symbol || row.want.overflow_error)
                pending_results = {pending_results, row.want};
        end
        else
            foreach (res[i]) pending_results = {pending_results, res[i]};
        burst_left--;
        @(negedge clk);
    endtask

    // receiver stalls on its own pattern: free running, random, or long holds
    initial
    begin
        int phase_left;
        int style;
        out_ready = 1'b0;
        phase_left = 0;
        style = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                style = $urandom_range(0, 2);
                phase_left = $urandom_range(5, 60);
            end
            phase_left--;
            case (style)
                0: out_ready = 1'b1;
                1: out_ready = ($urandom_range(0, 3) != 0);
                default: out_ready = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: symbol %0d has_symbol %0b overflow %0b last %0b",
                       out_data.symbol, out_data.has_symbol, out_data.overflow_error,
                       out_data.last);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", want.symbol, out_data.symbol);
                    fail_count++;
                end
                if (out_data.has_symbol !== want.has_symbol)
                begin
                    $error("has_symbol: expected %0b, got %0b", want.has_symbol,
                           out_data.has_symbol);
                    fail_count++;
                end
                if (out_data.overflow_error !== want.overflow_error)
                begin
                    $error("overflow_error: expected %0b, got %0b", want.overflow_error,
                           out_data.overflow_error);
                    fail_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, out_data.last);
                    fail_count++;
                end
                if (want.has_symbol)
                    symbols_seen++;
                if (want.overflow_error)
                    overflows_seen++;
            end
        end
    end

    // watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_huffman_bit_decoder_core: errors");
            $finish;
        end
    end

    initial
    begin
        out_t ovf_last;
        out_t none;
        stim_row_t row;
        int pick;
        int len;
        fail_count = 0;
        idle_cycles = 0;
        symbols_seen = 0;
        overflows_seen = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        clear_decoder();

        ovf_last = '0;
        ovf_last.overflow_error = 1'b1;
        ovf_last.last = 1'b1;
        none = '0;

        // empty table after reset: 32 ones overflow on the fourth byte
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8), 1'b1, ovf_last);
        add_row(make_item(MODE_LOAD, 0, 1, 32'h0, 0, 0));
        add_row(make_item(MODE_LOAD, 255, 32, 32'hFFFF_FFFF, 0, 0));
        // stray bits above the length are dropped
        add_row(make_item(MODE_LOAD, 1, 2, 32'hFFFF_FFFE, 0, 0));
        // overlong and zero length both leave the entry invalid
        add_row(make_item(MODE_LOAD, 2, 40, 32'h0, 0, 0));
        add_row(make_item(MODE_LOAD, 3, 0, 32'h1, 0, 0));
        add_row(make_item(MODE_LOAD, 4, 63, 32'h3, 0, 0));
        // same code as symbol 0; the lower symbol wins
        add_row(make_item(MODE_LOAD, 5, 1, 32'h0, 0, 0));
        add_row(make_item(2'd3, 7, 1, 32'h1, 8'h00, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'h00, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'h00, 0), 1'b1, none);
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'h5A, 15));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'h80, 2));
        // a code split across two bytes, padding ignored
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hBF, 1));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'h7F, 1));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'hFF, 8));
        add_row(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
        add_row(make_item(MODE_DECODE, 0, 0, 0, 8'h00, 8));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        clear_decoder();
        @(negedge clk);

        foreach (directed[i]) send_item(directed[i]);

        // random part: short codes over a persistent table, with some noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            row.typed = 1'b0;
            row.want = '0;
            if (pick < 3)
                row.item = make_item(MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 63),
                                     $urandom, $urandom_range(0, 255), $urandom_range(0, 15));
            else if (pick < 22)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 5);
                row.item = make_item(MODE_LOAD, $urandom_range(0, 255), len, $urandom,
                                     $urandom_range(0, 255), $urandom_range(0, 15));
            end
            else if (pick < 26)
                row.item = make_item(2'd3, $urandom_range(0, 255), $urandom_range(0, 63),
                                     $urandom, $urandom_range(0, 255), $urandom_range(0, 15));
            else
                row.item = make_item(MODE_DECODE, $urandom_range(0, 255), $urandom_range(0, 63),
                                     $urandom, $urandom_range(0, 255),
                                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 8);
            send_item(row);
        end
        in_valid = 1'b0;

        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d directed and %0d random items", directed.size(), RANDOM_ITEMS);
        $display("checked %0d decoded symbols and %0d overflows", symbols_seen, overflows_seen);
        if (fail_count == 0)
            $display("tb_huffman_bit_decoder_core: clean");
        else
            $display("tb_huffman_bit_decoder_core: errors");
        $finish;
    end

endmodule

FILE: huffman_bit_decoder_core.f
hw/rtl/hbd_pkg.sv
hw/rtl/hbd_match.sv
hw/rtl/huffman_bit_decoder_core.sv
test/tb_huffman_bit_decoder_core.sv
